FILE: hw/rtl/ctxid_pkg.sv
// ============================================================================
// ctxid_pkg
// Shared types, codes and constants of the context-ID table.
// ============================================================================
package ctxid_pkg;

    localparam int DEF_TABLE_SLOTS = 64;
    localparam int DEF_ID_LIMIT    = 4096;

    localparam int ID_W     = 12;
    localparam int ADDR_W   = 64;
    localparam int CNT_W    = 32;
    localparam int SLOT_W   = 6;
    localparam int IN_W     = 216;
    localparam int OUT_W    = 352;
    localparam int CFG_IDX_W = 1;

    localparam logic [ID_W-1:0]   ID_FIRST  = 12'd1;
    localparam logic [ADDR_W-1:0] PAGE_MASK = 64'hFFF;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_ID_EN  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_INV_EN = 1'd1;

    typedef enum logic [2:0] {
        OP_ALLOC  = 3'd0,
        OP_FREE   = 3'd1,
        OP_SWITCH = 3'd2,
        OP_INVAL  = 3'd3,
        OP_SETG   = 3'd4,
        OP_QUERYG = 3'd5,
        OP_READ   = 3'd6,
        OP_CLEAR  = 3'd7
    } t_op;

    // invalidate kinds
    localparam logic [1:0] KIND_ADDR    = 2'd0;
    localparam logic [1:0] KIND_CTX     = 2'd1;
    localparam logic [1:0] KIND_ALL     = 2'd2;
    localparam logic [1:0] KIND_NONGLOB = 2'd3;

    localparam logic [1:0] ST_DONE     = 2'd0;
    localparam logic [1:0] ST_DISABLED = 2'd1;
    localparam logic [1:0] ST_NOMATCH  = 2'd2;

    typedef enum logic [2:0] {
        S_IDLE,
        S_START,
        S_READ,
        S_EVAL,
        S_FINISH
    } t_state;

    // one input beat, last field in the low bits
    typedef struct packed {
        logic [ADDR_W-1:0] time_now;
        logic [SLOT_W-1:0] slot;
        logic              global_flag;
        logic [ADDR_W-1:0] lin_addr;
        logic [1:0]        flush_kind;
        logic [ADDR_W-1:0] pt_base;
        logic [ID_W-1:0]   context_id;
        t_op               req_type;
    } t_req;

    // one output beat, last field in the low bits
    typedef struct packed {
        logic [3:0]        pad;
        logic [CNT_W-1:0]  invalidate_count;
        logic [CNT_W-1:0]  switch_count;
        logic [CNT_W-1:0]  total_flushes;
        logic [ADDR_W-1:0] entry_stamp;
        logic [CNT_W-1:0]  entry_flushes;
        logic              entry_active;
        logic [ADDR_W-1:0] entry_base;
        logic [ID_W-1:0]   entry_id;
        logic              global_out;
        logic [ADDR_W-1:0] combined_value;
        logic [ID_W-1:0]   result_id;
        logic [1:0]        status;
    } t_res;

    // one table entry as stored in memory
    typedef struct packed {
        logic [ID_W-1:0]   id;
        logic [ADDR_W-1:0] base;
        logic [CNT_W-1:0]  flushes;
        logic [ADDR_W-1:0] stamp;
    } t_entry;

    typedef struct packed {
        logic latch;
        logic start;
        logic rd;
        logic ev;
        logic fin;
    } t_cmd;

    typedef struct packed {
        logic need_scan;
        logic first_only;
        logic hit;
        logic last;
        logic out_free;
    } t_sts;

endpackage

FILE: hw/rtl/context_id_table.sv
// ============================================================================
// context_id_table
// Table of context-ID entries with allocate, free, switch, invalidate,
// global-bit access, slot read-back and counter clearing.
// ============================================================================
// a request that needs no table walk passes the start step and then the finish
//   step into the result register; a walk adds a registered memory read and an
//   evaluate-and-write-back step for each slot visited, up to TABLE_SLOTS slots
// one request at a time: the next beat is taken only after the result has loaded;
//   an untaken result holds the finish step
// reset: synchronous active low; entries read as zero through per-slot valid
//   bits, so no clearing pass is needed and a request is taken right after reset
module context_id_table #(
    parameter int TABLE_SLOTS = ctxid_pkg::DEF_TABLE_SLOTS,
    parameter int ID_LIMIT    = ctxid_pkg::DEF_ID_LIMIT
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // config write port: index 0 id_enable, index 1 invalidate_enable
    input  logic                            i_cfg_we,
    input  logic [ctxid_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic                            i_cfg_data,
    // request side
    input  logic                            i_s_tvalid,
    output logic                            o_s_tready,
    // tdata, low bit up: req_type, context_id, pt_base, flush_kind,
    // lin_addr, global_flag, slot, time_now
    input  logic [ctxid_pkg::IN_W-1:0]      i_s_tdata,
    // result side
    output logic                            o_m_tvalid,
    input  logic                            i_m_tready,
    // tdata, low bit up: status, result_id, combined_value, global_out,
    // entry_id, entry_base, entry_active, entry_flushes, entry_stamp,
    // total_flushes, switch_count, invalidate_count, zero pad
    output logic [ctxid_pkg::OUT_W-1:0]     o_m_tdata
);

    // command and status between sequencer and datapath
    ctxid_pkg::t_cmd cmd;
    ctxid_pkg::t_sts sts;

    // sequencer: idle, start, read/evaluate per slot, finish into output register
    ctxid_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_s_tvalid),
        .o_ready (o_s_tready),
        .i_sts   (sts),
        .o_cmd   (cmd)
    );

    // datapath: the result register lets a finished beat wait while the
    // next request is taken
    ctxid_dp #(
        .TABLE_SLOTS (TABLE_SLOTS),
        .ID_LIMIT    (ID_LIMIT)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_in_data   (i_s_tdata),
        .o_out_valid (o_m_tvalid),
        .i_out_ready (i_m_tready),
        .o_out_data  (o_m_tdata),
        .i_cmd       (cmd),
        .o_sts       (sts)
    );

endmodule

FILE: hw/rtl/ctxid_ctrl.sv
// ============================================================================
// ctxid_ctrl
// Sequencer: takes a request, walks the table slot by slot, hands off result.
// ============================================================================
module ctxid_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  ctxid_pkg::t_sts   i_sts,
    output ctxid_pkg::t_cmd   o_cmd
);

    ctxid_pkg::t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ctxid_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ctxid_pkg::S_IDLE: begin
                if (i_valid) n_state = ctxid_pkg::S_START;
            end
            ctxid_pkg::S_START: begin
                n_state = i_sts.need_scan ? ctxid_pkg::S_READ : ctxid_pkg::S_FINISH;
            end
            ctxid_pkg::S_READ: begin
                n_state = ctxid_pkg::S_EVAL;
            end
            ctxid_pkg::S_EVAL: begin
                if ((i_sts.hit && i_sts.first_only) || i_sts.last)
                    n_state = ctxid_pkg::S_FINISH;
                else
                    n_state = ctxid_pkg::S_READ;
            end
            ctxid_pkg::S_FINISH: begin
                if (i_sts.out_free) n_state = ctxid_pkg::S_IDLE;
            end
            default: n_state = ctxid_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd   = '0;
        o_ready = 1'b0;
        case (r_state)
            ctxid_pkg::S_IDLE: begin
                o_ready     = 1'b1;
                o_cmd.latch = i_valid;
            end
            ctxid_pkg::S_START:  o_cmd.start = 1'b1;
            ctxid_pkg::S_READ:   o_cmd.rd    = 1'b1;
            ctxid_pkg::S_EVAL:   o_cmd.ev    = 1'b1;
            ctxid_pkg::S_FINISH: o_cmd.fin   = i_sts.out_free;
            default: o_cmd = '0;
        endcase
    end

endmodule

FILE: hw/rtl/ctxid_dp.sv
// ============================================================================
// ctxid_dp
// Datapath: request register, entry memory, flag bits, counters, result beat.
// ============================================================================
module ctxid_dp #(
    parameter int TABLE_SLOTS = ctxid_pkg::DEF_TABLE_SLOTS,
    parameter int ID_LIMIT    = ctxid_pkg::DEF_ID_LIMIT
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [ctxid_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic                              i_cfg_data,
    input  logic [ctxid_pkg::IN_W-1:0]        i_in_data,
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output logic [ctxid_pkg::OUT_W-1:0]       o_out_data,
    input  ctxid_pkg::t_cmd                   i_cmd,
    output ctxid_pkg::t_sts                   o_sts
);

    localparam int IW = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
    localparam logic [IW-1:0] LAST_IDX = IW'(TABLE_SLOTS - 1);
    localparam logic [ctxid_pkg::ID_W:0] ID_LIM = (ctxid_pkg::ID_W + 1)'(ID_LIMIT);

    ctxid_pkg::t_req   r_req;
    logic [IW-1:0]     r_idx;
    logic              r_id_en, r_inv_en;
    ctxid_pkg::t_entry r_mem [TABLE_SLOTS];
    ctxid_pkg::t_entry r_rd;
    logic              r_rd_vld;
    logic [TABLE_SLOTS-1:0] r_mvld, r_active, r_global;
    logic [ctxid_pkg::ID_W-1:0]  r_next_id, r_cur_id;
    logic [ctxid_pkg::CNT_W-1:0] r_fl_tot, r_sw_tot, r_inv_tot;
    logic              r_found;
    logic              r_gout, r_eact;
    ctxid_pkg::t_entry r_ecap;
    logic              r_out_valid;
    ctxid_pkg::t_res   r_res, n_res;

    ctxid_pkg::t_entry e, wdata;
    logic              act, hit, wr_mem, in_range, id_match, need_scan;
    logic [ctxid_pkg::ID_W:0] next_inc;

    assign in_range = (32'(r_req.slot) < TABLE_SLOTS);
    assign e        = r_rd_vld ? r_rd : '0;
    assign act      = r_active[r_idx];
    assign id_match = (e.id == r_req.context_id);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_id_en  <= 1'b0;
            r_inv_en <= 1'b0;
        end else if (i_cfg_we) begin
            if (i_cfg_idx == ctxid_pkg::CFG_ID_EN)  r_id_en  <= i_cfg_data;
            if (i_cfg_idx == ctxid_pkg::CFG_INV_EN) r_inv_en <= i_cfg_data;
        end
    end

    // scan control status
    always_comb begin
        need_scan = 1'b0;
        hit       = 1'b0;
        wr_mem    = 1'b0;
        wdata     = e;
        case (r_req.req_type)
            ctxid_pkg::OP_ALLOC: begin
                need_scan       = r_id_en;
                hit             = !act;
                wr_mem          = 1'b1;
                wdata.id        = r_next_id;
                wdata.base      = r_req.pt_base;
                wdata.flushes   = '0;
                wdata.stamp     = r_req.time_now;
            end
            ctxid_pkg::OP_FREE: begin
                need_scan       = r_id_en;
                hit             = act && id_match;
                wr_mem          = 1'b1;
                wdata.id        = '0;
                wdata.base      = '0;
            end
            ctxid_pkg::OP_SWITCH: begin
                need_scan       = r_id_en;
                hit             = id_match;
                wr_mem          = 1'b1;
                wdata.stamp     = r_req.time_now;
            end
            ctxid_pkg::OP_INVAL: begin
                need_scan       = r_inv_en && r_req.flush_kind[0];
                hit             = (r_req.flush_kind == ctxid_pkg::KIND_NONGLOB) || id_match;
                wr_mem          = 1'b1;
                wdata.flushes   = e.flushes + 1'b1;
            end
            ctxid_pkg::OP_SETG, ctxid_pkg::OP_QUERYG: begin
                need_scan       = 1'b1;
                hit             = act && id_match;
            end
            ctxid_pkg::OP_READ: begin
                need_scan       = in_range;
                hit             = 1'b1;
            end
            ctxid_pkg::OP_CLEAR: begin
                need_scan       = 1'b1;
                hit             = 1'b1;
                wr_mem          = 1'b1;
                wdata.flushes   = '0;
            end
            default: need_scan = 1'b0;
        endcase
    end

    assign o_sts.need_scan  = need_scan;
    assign o_sts.first_only = (r_req.req_type != ctxid_pkg::OP_INVAL) &&
                              (r_req.req_type != ctxid_pkg::OP_CLEAR);
    assign o_sts.hit        = hit;
    assign o_sts.last       = (r_idx == LAST_IDX) || (r_req.req_type == ctxid_pkg::OP_READ);
    assign o_sts.out_free   = !r_out_valid || i_out_ready;

    // entry memory, registered read
    always_ff @(posedge i_clk) begin
        if (i_cmd.rd) r_rd <= r_mem[r_idx];
        if (i_cmd.ev && hit && wr_mem) r_mem[r_idx] <= wdata;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mvld   <= '0;
            r_active <= '0;
            r_global <= '0;
            r_rd_vld <= 1'b0;
        end else begin
            if (i_cmd.rd) r_rd_vld <= r_mvld[r_idx];
            if (i_cmd.ev && hit) begin
                if (wr_mem) r_mvld[r_idx] <= 1'b1;
                case (r_req.req_type)
                    ctxid_pkg::OP_ALLOC: begin
                        r_active[r_idx] <= 1'b1;
                        r_global[r_idx] <= 1'b0;
                    end
                    ctxid_pkg::OP_FREE: r_active[r_idx] <= 1'b0;
                    ctxid_pkg::OP_SETG: r_global[r_idx] <= r_req.global_flag;
                    default: ;
                endcase
            end
        end
    end

    // request register, slot counter, captures
    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) r_req <= ctxid_pkg::t_req'(i_in_data);
        if (i_cmd.start) begin
            r_idx   <= (r_req.req_type == ctxid_pkg::OP_READ) ? IW'(r_req.slot) : '0;
            r_found <= 1'b0;
            r_gout  <= 1'b0;
            r_eact  <= 1'b0;
            r_ecap  <= '0;
        end
        if (i_cmd.ev) begin
            if (r_idx != LAST_IDX) r_idx <= r_idx + 1'b1;
            if (hit) begin
                r_found <= 1'b1;
                if (r_req.req_type == ctxid_pkg::OP_QUERYG) r_gout <= r_global[r_idx];
                if (r_req.req_type == ctxid_pkg::OP_READ) begin
                    r_gout <= r_global[r_idx];
                    r_eact <= act;
                    r_ecap <= e;
                end
            end
        end
    end

    assign next_inc = {1'b0, r_next_id} + 1'b1;

    // result beat
    always_comb begin
        n_res                  = '0;
        n_res.status           = ctxid_pkg::ST_DONE;
        n_res.result_id        = r_cur_id;
        n_res.total_flushes    = r_fl_tot;
        n_res.switch_count     = r_sw_tot;
        n_res.invalidate_count = r_inv_tot;
        n_res.global_out       = r_gout;
        n_res.entry_id         = r_ecap.id;
        n_res.entry_base       = r_ecap.base;
        n_res.entry_active     = r_eact;
        n_res.entry_flushes    = r_ecap.flushes;
        n_res.entry_stamp      = r_ecap.stamp;
        case (r_req.req_type)
            ctxid_pkg::OP_ALLOC: begin
                n_res.result_id = '0;
                if (!r_id_en)      n_res.status = ctxid_pkg::ST_DISABLED;
                else if (!r_found) n_res.status = ctxid_pkg::ST_NOMATCH;
                else               n_res.result_id = r_next_id;
            end
            ctxid_pkg::OP_FREE: begin
                if (!r_id_en)      n_res.status = ctxid_pkg::ST_DISABLED;
                else if (!r_found) n_res.status = ctxid_pkg::ST_NOMATCH;
            end
            ctxid_pkg::OP_SWITCH: begin
                if (!r_id_en) begin
                    n_res.status = ctxid_pkg::ST_DISABLED;
                end else begin
                    n_res.result_id      = r_req.context_id;
                    n_res.combined_value = r_req.pt_base |
                                           ctxid_pkg::ADDR_W'(r_req.context_id);
                    n_res.switch_count   = r_sw_tot + 1'b1;
                end
            end
            ctxid_pkg::OP_INVAL: begin
                if (!r_inv_en) begin
                    n_res.status = ctxid_pkg::ST_DISABLED;
                end else begin
                    n_res.combined_value   = ctxid_pkg::ADDR_W'(r_req.context_id) |
                                             (r_req.lin_addr & ~ctxid_pkg::PAGE_MASK);
                    n_res.total_flushes    = r_fl_tot + 1'b1;
                    n_res.invalidate_count = r_inv_tot + 1'b1;
                end
            end
            ctxid_pkg::OP_SETG, ctxid_pkg::OP_QUERYG: begin
                if (!r_found) n_res.status = ctxid_pkg::ST_NOMATCH;
            end
            ctxid_pkg::OP_READ: begin
                if (!in_range) n_res.status = ctxid_pkg::ST_NOMATCH;
            end
            ctxid_pkg::OP_CLEAR: begin
                n_res.total_flushes    = '0;
                n_res.switch_count     = '0;
                n_res.invalidate_count = '0;
            end
            default: n_res.status = ctxid_pkg::ST_DONE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_next_id   <= ctxid_pkg::ID_FIRST;
            r_cur_id    <= '0;
            r_fl_tot    <= '0;
            r_sw_tot    <= '0;
            r_inv_tot   <= '0;
        end else begin
            if (i_cmd.fin) begin
                r_out_valid <= 1'b1;
                r_fl_tot    <= n_res.total_flushes;
                r_sw_tot    <= n_res.switch_count;
                r_inv_tot   <= n_res.invalidate_count;
                // allocate reports the new id but leaves the current id alone
                if (r_req.req_type != ctxid_pkg::OP_ALLOC) r_cur_id <= n_res.result_id;
                if (r_req.req_type == ctxid_pkg::OP_ALLOC && r_id_en && r_found) begin
                    r_next_id <= (next_inc >= ID_LIM) ? ctxid_pkg::ID_FIRST
                                                      : next_inc[ctxid_pkg::ID_W-1:0];
                end
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.fin) r_res <= n_res;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_res;

endmodule

FILE: hw/rtl/ctxid_checker.sv
// ============================================================================
// ctxid_checker
// Port-level checks of the context-ID table, bound to the top level.
// ============================================================================
module ctxid_checker (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            i_cfg_we,
    input logic [ctxid_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input logic                            i_cfg_data,
    input logic                            i_s_tvalid,
    input logic                            o_s_tready,
    input logic [ctxid_pkg::IN_W-1:0]      i_s_tdata,
    input logic                            o_m_tvalid,
    input logic                            i_m_tready,
    input logic [ctxid_pkg::OUT_W-1:0]     o_m_tdata
);

    // no result beat right after reset
    a_rst_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid)
        else $error("result beat after reset");

    // one request at a time: accepted beat drops ready
    a_one_req: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_tvalid && o_s_tready) |=> !o_s_tready)
        else $error("second request taken while busy");

    // status code three is never produced
    a_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> (o_m_tdata[1:0] != 2'd3))
        else $error("bad status");

    // stalled result beat holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !i_m_tready) |=> (o_m_tvalid && $stable(o_m_tdata)))
        else $error("stalled result changed");

endmodule

bind context_id_table ctxid_checker u_ctxid_checker (.*);
